[rtl/core/lbrl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky bucket rate limiter package
// Shared types and constants for the limiter front, queue, divider and back.
// ----------------------------------------------------------------------------
package lbrl_pkg;

	// nanounits per unit and nanoseconds per second
	localparam logic [29:0] NANO_PER_UNIT = 30'd1000000000;
	localparam logic [29:0] NS_MAX        = 30'd999999999;
	// floor(2^61 / 1e9): quotient estimate from bits [59:29] of a dividend
	localparam logic [31:0] RECIP_NS      = 32'd2305843009;
	// decimal scaling of the nanosecond part of the wait
	localparam logic [16:0] SCALE_HI      = 17'd100000;
	localparam logic [13:0] SCALE_LO      = 14'd10000;
	// radix-2 divider steps
	localparam int          DIV_STEPS     = 64;

	// configuration register indexes
	localparam logic CFG_DRAIN_RATE = 1'b0;
	localparam logic CFG_CAPACITY   = 1'b1;

	typedef struct packed {
		logic [39:0] drain_rate;
		logic [63:0] bucket_capacity;
	} cfg_t;

	// queued item: time as seconds plus nanoseconds below one second
	typedef struct packed {
		logic [32:0] t_secs;
		logic [29:0] t_ns;
		logic [31:0] submit;
	} item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [39:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic [39:0] rem;
	} div_rsp_t;

endpackage

[rtl/core/lbrl_intf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky bucket rate limiter channels
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lbrl_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] now_seconds;
	logic [29:0] now_nanoseconds;
	logic [31:0] submit_units;

	modport source(output valid, now_seconds, now_nanoseconds, submit_units, input ready);
	modport sink(input valid, now_seconds, now_nanoseconds, submit_units, output ready);
endinterface

interface lbrl_out_if;
	logic        valid;
	logic        ready;
	logic        would_overflow;
	logic [63:0] wait_seconds;
	logic [29:0] wait_nanoseconds;
	logic [63:0] level_after;

	modport source(output valid, would_overflow, wait_seconds, wait_nanoseconds,
		level_after, input ready);
	modport sink(input valid, would_overflow, wait_seconds, wait_nanoseconds,
		level_after, output ready);
endinterface

interface lbrl_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[rtl/core/lbrl_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter item queue
// Two-entry queue between the accepting front and the processing back.
// ----------------------------------------------------------------------------
module lbrl_fifo
	import lbrl_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_data,
	input  logic  rd_en,
	output item_t rd_data,
	output logic  full,
	output logic  empty
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			if (wr_en && !rd_en) count_q <= count_q + 2'd1;
			else if (rd_en && !wr_en) count_q <= count_q - 2'd1;
		end
	end

endmodule

[rtl/core/lbrl_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter front
// Accepts input transactions and normalizes the timestamp.
// ----------------------------------------------------------------------------
module lbrl_front
	import lbrl_pkg::*;
(
	lbrl_in_if.sink in_item,
	input  logic    q_full,
	output logic    q_wr_en,
	output item_t   q_wr_data
);

	logic ns_wrap;

	assign in_item.ready = !q_full;
	assign q_wr_en       = in_item.valid && !q_full;

	// an oversized nanosecond field carries one second
	assign ns_wrap          = (in_item.now_nanoseconds >= NANO_PER_UNIT);
	assign q_wr_data.t_secs = {1'b0, in_item.now_seconds} + 33'(ns_wrap);
	assign q_wr_data.t_ns   = ns_wrap ? in_item.now_nanoseconds - NANO_PER_UNIT
		: in_item.now_nanoseconds;
	assign q_wr_data.submit = in_item.submit_units;

endmodule

[rtl/core/lbrl_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter divider
// Shared restoring radix-2 divider, 64-bit dividend by 40-bit divisor.
// ----------------------------------------------------------------------------
module lbrl_div
	import lbrl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [39:0] rem_q;
	logic [63:0] quot_q;
	logic [39:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [40:0] shifted;
	logic [40:0] diff;
	logic        ge;

	// one quotient bit per cycle
	assign shifted = {rem_q, quot_q[63]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = (shifted >= {1'b0, div_q});

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			quot_q <= req.dividend;
			div_q  <= req.divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[39:0] : shifted[39:0];
			quot_q <= {quot_q[62:0], ge};
		end
	end

endmodule

[rtl/core/lbrl_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Limiter back
// Sequencer for drain, overflow check, wait time and submission per item.
// ----------------------------------------------------------------------------
module lbrl_back
	import lbrl_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     q_empty,
	input  item_t    q_rd_data,
	output logic     q_rd_en,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	lbrl_out_if.source out_result
);

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF, S_CDE, S_CDR, S_CDF, S_MUL1, S_MUL2, S_ADDA,
		S_SUM1, S_SUM2, S_APPLY, S_CHECK, S_DIVW, S_P1, S_DIVP1, S_P2,
		S_DIVP2, S_NS, S_NSFIX, S_SUBMIT, S_OUT
	} state_t;

	// which division by 1e9 is running
	typedef enum logic {
		CD_RATE, CD_NANO
	} cd_sel_t;

	state_t      state_q;
	item_t       item_q;
	logic [32:0] last_s_q;
	logic [29:0] last_ns_q;
	logic [63:0] level_q;
	logic [29:0] frac_q;
	div_req_t    div_req_q;

	// division by 1e9
	cd_sel_t     cd_sel_q;
	logic [59:0] cd_x_q;
	logic [31:0] cd_q_q;
	logic [31:0] cd_r_q;

	// drain datapath
	logic [34:0] secs_q;
	logic [29:0] nsd_q;
	logic [10:0] rq_q;
	logic [29:0] rr_q;
	logic [57:0] pa_lo_q;
	logic [56:0] pa_hi_q;
	logic [40:0] b_q;
	logic [59:0] nprod_q;
	logic [63:0] a_q;
	logic        ovf_q;
	logic [29:0] c_q;
	logic [29:0] fracn_q;
	logic [63:0] s1_q;
	logic [63:0] units_q;

	// wait datapath
	logic [63:0] ws_q;
	logic [29:0] wns_q;
	logic [39:0] rem_q;
	logic [16:0] q1_q;
	logic [39:0] r1_q;
	logic [13:0] q2_q;
	logic        r2nz_q;
	logic        over_q;

	// output register
	logic        out_valid_q;
	logic        ovr_out_q;
	logic [63:0] ws_out_q;
	logic [29:0] wns_out_q;
	logic [63:0] lvl_out_q;

	logic        ns_borrow;
	logic [63:0] cd_prod;
	logic [63:0] cd_rem;
	logic [74:0] a_full;
	logic [59:0] nano;
	logic [64:0] sum_ab;
	logic [64:0] sum_c;
	logic [63:0] backlog;
	logic [64:0] lvl_add;

	assign q_rd_en = (state_q == S_IDLE) && !q_empty;
	assign div_req = div_req_q;

	assign out_result.valid            = out_valid_q;
	assign out_result.would_overflow   = ovr_out_q;
	assign out_result.wait_seconds     = ws_out_q;
	assign out_result.wait_nanoseconds = wns_out_q;
	assign out_result.level_after      = lvl_out_q;

	// combinational pieces of the sequencer steps
	assign ns_borrow = (item_q.t_ns < last_ns_q);
	// estimate is at most two below the true quotient
	assign cd_prod = {33'd0, cd_x_q[59:29]} * {32'd0, RECIP_NS};
	assign cd_rem  = {4'd0, cd_x_q} - {32'd0, cd_q_q} * 64'(NANO_PER_UNIT);
	assign a_full  = {17'd0, pa_lo_q} + {pa_hi_q, 18'd0};
	assign nano    = 60'(frac_q) + nprod_q;
	assign sum_ab  = {1'b0, a_q} + 65'(b_q);
	assign sum_c   = {1'b0, s1_q} + 65'(c_q);
	assign backlog = (level_q - cfg.bucket_capacity == '1) ? '1
		: level_q - cfg.bucket_capacity + 64'd1;
	assign lvl_add = {1'b0, level_q} + 65'(item_q.submit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_s_q    <= '0;
			last_ns_q   <= '0;
			level_q     <= '0;
			frac_q      <= '0;
			div_req_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_result.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						item_q  <= q_rd_data;
						state_q <= S_DIFF;
					end
				end
				// elapsed time; a backward step drains nothing
				S_DIFF: begin
					last_s_q  <= item_q.t_secs;
					last_ns_q <= item_q.t_ns;
					if ({item_q.t_secs, item_q.t_ns} < {last_s_q, last_ns_q}) begin
						state_q <= S_CHECK;
					end else begin
						secs_q   <= 35'(item_q.t_secs - last_s_q - 33'(ns_borrow));
						nsd_q    <= ns_borrow ? item_q.t_ns + NANO_PER_UNIT - last_ns_q
							: item_q.t_ns - last_ns_q;
						cd_x_q   <= 60'(cfg.drain_rate);
						cd_sel_q <= CD_RATE;
						state_q  <= S_CDE;
					end
				end
				// division by 1e9: reciprocal estimate, then correction
				S_CDE: begin
					cd_q_q  <= cd_prod[63:32];
					state_q <= S_CDR;
				end
				S_CDR: begin
					cd_r_q  <= cd_rem[31:0];
					state_q <= S_CDF;
				end
				S_CDF: begin
					if (cd_r_q >= 32'(NANO_PER_UNIT)) begin
						cd_r_q <= cd_r_q - 32'(NANO_PER_UNIT);
						cd_q_q <= cd_q_q + 32'd1;
					end else if (cd_sel_q == CD_RATE) begin
						rq_q    <= cd_q_q[10:0];
						rr_q    <= cd_r_q[29:0];
						state_q <= S_MUL1;
					end else begin
						c_q     <= cd_q_q[29:0];
						fracn_q <= cd_r_q[29:0];
						state_q <= S_SUM1;
					end
				end
				// rate * seconds in two partial products, with the nanosecond products beside them
				S_MUL1: begin
					pa_lo_q <= 58'(cfg.drain_rate) * 58'(secs_q[17:0]);
					b_q     <= 41'(rq_q) * 41'(nsd_q);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					pa_hi_q <= 57'(cfg.drain_rate) * 57'(secs_q[34:18]);
					nprod_q <= 60'(rr_q) * 60'(nsd_q);
					state_q <= S_ADDA;
				end
				S_ADDA: begin
					a_q      <= a_full[63:0];
					ovf_q    <= |a_full[74:64];
					cd_x_q   <= nano;
					cd_sel_q <= CD_NANO;
					state_q  <= S_CDE;
				end
				S_SUM1: begin
					s1_q    <= sum_ab[63:0];
					ovf_q   <= ovf_q | sum_ab[64];
					state_q <= S_SUM2;
				end
				S_SUM2: begin
					units_q <= sum_c[63:0];
					ovf_q   <= ovf_q | sum_c[64];
					state_q <= S_APPLY;
				end
				// drain the level, or clear it when the count overflowed
				S_APPLY: begin
					if (ovf_q) begin
						level_q <= '0;
						frac_q  <= '0;
					end else begin
						level_q <= (units_q < level_q) ? level_q - units_q : '0;
						frac_q  <= fracn_q;
					end
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					over_q <= (level_q == '1) || (level_q >= cfg.bucket_capacity);
					if (level_q >= cfg.bucket_capacity) begin
						if (cfg.drain_rate == '0) begin
							ws_q    <= '1;
							wns_q   <= NS_MAX;
							state_q <= S_SUBMIT;
						end else begin
							div_req_q <= '{1'b1, backlog, cfg.drain_rate};
							state_q   <= S_DIVW;
						end
					end else begin
						ws_q    <= '0;
						wns_q   <= '0;
						state_q <= S_SUBMIT;
					end
				end
				S_DIVW: begin
					if (div_rsp.done) begin
						ws_q    <= div_rsp.quot;
						rem_q   <= div_rsp.rem;
						state_q <= S_P1;
					end else begin
						div_req_q.start <= 1'b0;
					end
				end
				// nanoseconds in two decimal steps keep the products narrow
				S_P1: begin
					div_req_q <= '{1'b1, 64'(57'(rem_q) * 57'(SCALE_HI)), cfg.drain_rate};
					state_q   <= S_DIVP1;
				end
				S_DIVP1: begin
					if (div_rsp.done) begin
						q1_q    <= div_rsp.quot[16:0];
						r1_q    <= div_rsp.rem;
						state_q <= S_P2;
					end else begin
						div_req_q.start <= 1'b0;
					end
				end
				S_P2: begin
					div_req_q <= '{1'b1, 64'(54'(r1_q) * 54'(SCALE_LO)), cfg.drain_rate};
					state_q   <= S_DIVP2;
				end
				S_DIVP2: begin
					if (div_rsp.done) begin
						q2_q    <= div_rsp.quot[13:0];
						r2nz_q  <= (div_rsp.rem != '0);
						state_q <= S_NS;
					end else begin
						div_req_q.start <= 1'b0;
					end
				end
				S_NS: begin
					wns_q   <= 30'(q1_q) * 30'(SCALE_LO) + 30'(q2_q) + 30'(r2nz_q);
					state_q <= S_NSFIX;
				end
				// carry a full second, and never report a zero wait
				S_NSFIX: begin
					if (wns_q >= NANO_PER_UNIT) begin
						wns_q <= wns_q - NANO_PER_UNIT;
						ws_q  <= ws_q + 64'd1;
					end else if (ws_q == '0 && wns_q == '0) begin
						wns_q <= 30'd1;
					end
					state_q <= S_SUBMIT;
				end
				S_SUBMIT: begin
					level_q <= lvl_add[64] ? '1 : lvl_add[63:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_result.ready) begin
						out_valid_q <= 1'b1;
						ovr_out_q   <= over_q;
						ws_out_q    <= ws_q;
						wns_out_q   <= wns_q;
						lvl_out_q   <= level_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/leaky_bucket_rate_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leaky bucket rate limiter
// Drains a bucket by rate times elapsed time, reports overflow and wait time,
// then adds the submitted units.
// ----------------------------------------------------------------------------
// Channel      Dir  Handshake    Payload
// in_item      in   valid/ready  now_seconds, now_nanoseconds, submit_units
// out_result   out  valid/ready  would_overflow, wait_seconds,
//                                wait_nanoseconds, level_after
// cfg          in   valid/ready  index (0 drain_rate, 1 bucket_capacity), data
//
// A backward time step skips the drain. Each of the two divisions by 1e9 of a
// drain is a reciprocal estimate followed by a correction. A needed wait adds
// three divisions by the rate in the shared radix-2 divider, plus four steps.
// A two-entry queue lets the front accept while the back works; a result waits
// in the output register. Reset is asynchronous: level, fraction and last time
// clear, drain_rate and bucket_capacity return to 1.
// ----------------------------------------------------------------------------
module leaky_bucket_rate_limiter
	import lbrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lbrl_in_if.sink     in_item,
	lbrl_out_if.source  out_result,
	lbrl_cfg_if.sink    cfg
);

	cfg_t     cfg_q;
	logic     q_wr_en;
	item_t    q_wr_data;
	logic     q_rd_en;
	item_t    q_rd_data;
	logic     q_full;
	logic     q_empty;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drain_rate      <= 40'd1;
			cfg_q.bucket_capacity <= 64'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_DRAIN_RATE: cfg_q.drain_rate      <= cfg.data[39:0];
				CFG_CAPACITY:   cfg_q.bucket_capacity <= cfg.data;
				default: ;
			endcase
		end
	end

	lbrl_front u_front (
		.in_item   (in_item),
		.q_full    (q_full),
		.q_wr_en   (q_wr_en),
		.q_wr_data (q_wr_data)
	);

	lbrl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr_en),
		.wr_data (q_wr_data),
		.rd_en   (q_rd_en),
		.rd_data (q_rd_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	lbrl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	lbrl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_empty    (q_empty),
		.q_rd_data  (q_rd_data),
		.q_rd_en    (q_rd_en),
		.div_req    (div_req),
		.div_rsp    (div_rsp),
		.out_result (out_result)
	);

endmodule
